// ===== rtl/mrp_pkg.sv =====
`timescale 1ns / 1ps

package mrp_pkg;

  localparam int unsigned MAX_SAMPLING = 4;
  localparam int unsigned BLOCK_SHIFT  = 3;

  // Global pixel coordinate: 16-bit MCU index times at most 32, plus 5 bits.
  localparam int unsigned POS_W  = 21;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned SAMP_W = 3;
  localparam int unsigned PIX_W  = 24;
  localparam int unsigned ADDR_W = 32;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_H_SAMPLING   = 2'd2,
    CFG_V_SAMPLING   = 2'd3
  } cfg_idx_e;

  // Configuration as it is used: sizes at least one, sampling in range.
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [SAMP_W-1:0] h_samp;
    logic [SAMP_W-1:0] v_samp;
  } cfg_t;

  // Position of the current pixel as seen by the output pipeline.
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             kept;
    logic             done;
  } pos_t;

  function automatic logic [SAMP_W-1:0] eff_sampling(input logic [SAMP_W-1:0] s);
    logic [SAMP_W-1:0] r;
    if (s == '0) begin
      r = SAMP_W'(1);
    end else if (s > SAMP_W'(MAX_SAMPLING)) begin
      r = SAMP_W'(MAX_SAMPLING);
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    return (s == '0) ? SIZE_W'(1) : s;
  endfunction

endpackage

// ===== rtl/mrp_in_if.sv =====
`timescale 1ns / 1ps

interface mrp_in_if;
  logic                        valid;
  logic                        ready;
  logic [mrp_pkg::PIX_W-1:0]   pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// ===== rtl/mrp_out_if.sv =====
`timescale 1ns / 1ps

interface mrp_out_if;
  logic                        valid;
  logic                        ready;
  logic [mrp_pkg::ADDR_W-1:0]  pixel_address;
  logic [mrp_pkg::PIX_W-1:0]   pixel_data;
  logic                        image_done;

  modport source (output valid, output pixel_address, output pixel_data,
                  output image_done, input ready);
  modport sink   (input valid, input pixel_address, input pixel_data,
                  input image_done, output ready);
endinterface

// ===== rtl/mrp_pos.sv =====
`timescale 1ns / 1ps

module mrp_pos (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  mrp_pkg::cfg_t   cfg_i,
  output mrp_pkg::pos_t   pos_o
);

  localparam int unsigned LW = mrp_pkg::POS_W;
  localparam int unsigned SW = mrp_pkg::SIZE_W;
  localparam int unsigned MW = SW + mrp_pkg::SAMP_W;

  logic [4:0]    cim_q, cim_d;
  logic [4:0]    rim_q, rim_d;
  logic [SW-1:0] mcol_q, mcol_d;
  logic [SW-1:0] mrow_q, mrow_d;

  logic [5:0]    span_x, span_y;
  logic [MW-1:0] mul_x, mul_y;
  logic [LW-1:0] base_x, base_y;
  logic [LW:0]   next_base_x, next_base_y;
  logic [LW-1:0] col, row;
  logic [4:0]    cim_inc, rim_inc;
  logic [SW-1:0] mcol_inc, mrow_inc;
  logic          col_wrap, row_wrap, mcol_wrap, mrow_wrap;

  assign span_x = {cfg_i.h_samp, 3'b000};
  assign span_y = {cfg_i.v_samp, 3'b000};

  assign mul_x  = MW'(mcol_q) * MW'(cfg_i.h_samp);
  assign mul_y  = MW'(mrow_q) * MW'(cfg_i.v_samp);
  assign base_x = LW'({mul_x, 3'b000});
  assign base_y = LW'({mul_y, 3'b000});

  assign col = base_x + LW'(cim_q);
  assign row = base_y + LW'(rim_q);

  always_comb begin
    pos_o.col  = col;
    pos_o.row  = row;
    pos_o.kept = (6'(cim_q) < span_x) && (6'(rim_q) < span_y) &&
                 (col < LW'(cfg_i.width)) && (row < LW'(cfg_i.height));
    pos_o.done = (col == LW'(cfg_i.width - SW'(1))) &&
                 (row == LW'(cfg_i.height - SW'(1)));
  end

  // The MCU counters wrap once the next MCU would start at or beyond the edge,
  // which is the same test as comparing against the MCU count per line.
  assign next_base_x = (LW + 1)'(base_x) + (LW + 1)'(span_x);
  assign next_base_y = (LW + 1)'(base_y) + (LW + 1)'(span_y);

  assign cim_inc  = cim_q + 5'd1;
  assign rim_inc  = rim_q + 5'd1;
  assign mcol_inc = mcol_q + SW'(1);
  assign mrow_inc = mrow_q + SW'(1);

  assign col_wrap  = (cim_inc == '0) || (6'(cim_inc) >= span_x);
  assign row_wrap  = (rim_inc == '0) || (6'(rim_inc) >= span_y);
  assign mcol_wrap = (mcol_inc == '0) || (next_base_x >= (LW + 1)'(cfg_i.width));
  assign mrow_wrap = next_base_y >= (LW + 1)'(cfg_i.height);

  always_comb begin
    cim_d  = cim_q;
    rim_d  = rim_q;
    mcol_d = mcol_q;
    mrow_d = mrow_q;
    if (step_i) begin
      cim_d = col_wrap ? 5'd0 : cim_inc;
      if (col_wrap) begin
        rim_d = row_wrap ? 5'd0 : rim_inc;
        if (row_wrap) begin
          mcol_d = mcol_wrap ? '0 : mcol_inc;
          if (mcol_wrap) begin
            mrow_d = mrow_wrap ? '0 : mrow_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cim_q  <= '0;
      rim_q  <= '0;
      mcol_q <= '0;
      mrow_q <= '0;
    end else begin
      cim_q  <= cim_d;
      rim_q  <= rim_d;
      mcol_q <= mcol_d;
      mrow_q <= mrow_d;
    end
  end

`ifndef ASSERT_OFF
  // Without a step nothing in the position moves.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(cim_q) && $stable(rim_q) && $stable(mcol_q) && $stable(mrow_q))
    else $error("position counters moved without a step");

  // A column step that does not wrap leaves the row inside the MCU alone.
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !col_wrap |=> cim_q == $past(cim_q) + 5'd1 && $stable(rim_q))
    else $error("column step disturbed the row counter");

  // A kept pixel always lies inside the configured image.
  a_kept_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_o.kept |-> col < LW'(cfg_i.width) && row < LW'(cfg_i.height))
    else $error("kept pixel outside the image");
`endif

endmodule

// ===== rtl/mcu_to_raster_pixel_placer.sv =====
`timescale 1ns / 1ps

// A kept pixel passes through the stage 1 register and then the output register.
// Throughput: one input beat per cycle unless the output stalls with stage 1 full;
// each pixel steps the position counters once, and padding pixels give no output.
// Reset (asynchronous, active low) clears the position counters, empties the pipeline
// and loads the configuration defaults: 8x8 image, sampling 1 by 1.
module mcu_to_raster_pixel_placer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  mrp_in_if.sink              pix_in_i,
  mrp_out_if.source           pix_out_o
);

  localparam int unsigned LW = mrp_pkg::POS_W;
  localparam int unsigned SW = mrp_pkg::SIZE_W;
  localparam int unsigned AW = mrp_pkg::ADDR_W;
  localparam int unsigned PW = mrp_pkg::PIX_W;
  localparam int unsigned QW = LW + SW;

  mrp_pkg::cfg_t cfg_q, cfg_d;
  mrp_pkg::pos_t pos;

  logic          in_fire;
  logic          out_en, s1_en;

  logic          s1_valid_q, s1_valid_d;
  logic [LW-1:0] s1_col_q, s1_row_q;
  logic [SW-1:0] s1_w_q;
  logic [PW-1:0] s1_pix_q;
  logic          s1_done_q;

  logic          out_valid_q, out_valid_d;
  logic [AW-1:0] out_addr_q, addr_d;
  logic [PW-1:0] out_data_q;
  logic          out_done_q;
  logic [QW-1:0] prod;

  // Configuration is stored in its effective form.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (mrp_pkg::cfg_idx_e'(cfg_index_i))
        mrp_pkg::CFG_IMAGE_WIDTH:  cfg_d.width  = mrp_pkg::eff_size(cfg_data_i);
        mrp_pkg::CFG_IMAGE_HEIGHT: cfg_d.height = mrp_pkg::eff_size(cfg_data_i);
        mrp_pkg::CFG_H_SAMPLING:   cfg_d.h_samp =
                                     mrp_pkg::eff_sampling(cfg_data_i[mrp_pkg::SAMP_W-1:0]);
        mrp_pkg::CFG_V_SAMPLING:   cfg_d.v_samp =
                                     mrp_pkg::eff_sampling(cfg_data_i[mrp_pkg::SAMP_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= SW'(8);
      cfg_q.height <= SW'(8);
      cfg_q.h_samp <= mrp_pkg::SAMP_W'(1);
      cfg_q.v_samp <= mrp_pkg::SAMP_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Ready ripples back from the output register through the address stage.
  assign out_en         = !out_valid_q || pix_out_o.ready;
  assign s1_en          = !s1_valid_q || out_en;
  assign pix_in_i.ready = s1_en;
  assign in_fire        = pix_in_i.valid && s1_en;

  mrp_pos u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .cfg_i  (cfg_q),
    .pos_o  (pos)
  );

  // Stage 1 holds only pixels that produce an output beat.
  assign s1_valid_d = s1_en ? (in_fire && pos.kept) : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q  <= pos.col;
      s1_row_q  <= pos.row;
      s1_w_q    <= cfg_q.width;
      s1_pix_q  <= pix_in_i.pixel_value;
      s1_done_q <= pos.done;
    end
  end

  assign prod   = QW'(s1_row_q) * QW'(s1_w_q);
  assign addr_d = prod[AW-1:0] + AW'(s1_col_q);

  assign out_valid_d = out_en ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s1_valid_q) begin
      out_addr_q <= addr_d;
      out_data_q <= s1_pix_q;
      out_done_q <= s1_done_q;
    end
  end

  assign pix_out_o.valid         = out_valid_q;
  assign pix_out_o.pixel_address = out_addr_q;
  assign pix_out_o.pixel_data    = out_data_q;
  assign pix_out_o.image_done    = out_done_q;

`ifndef ASSERT_OFF
  // A waiting stage 1 beat keeps its contents while the output is stalled.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_en |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_row_q) &&
                              $stable(s1_pix_q) && $stable(s1_done_q))
    else $error("stage 1 beat changed while stalled");

  // An empty stage 1 never blocks the input.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> pix_in_i.ready)
    else $error("input stalled with an empty pipeline");

  // Only in-image columns reach the address stage.
  a_s1_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> s1_col_q < LW'(s1_w_q))
    else $error("column beyond image width in address stage");

  // A beat moves from stage 1 to the output whenever the output can take it.
  a_s1_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_en |=> out_valid_q && out_data_q == $past(s1_pix_q))
    else $error("stage 1 beat not transferred to output");
`endif

endmodule

// ===== tb/tb_mcu_to_raster_pixel_placer.sv =====
`timescale 1ns / 1ps

module tb_mcu_to_raster_pixel_placer;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct {
    logic [mrp_pkg::ADDR_W-1:0] addr;
    logic [mrp_pkg::PIX_W-1:0]  data;
    logic                       done;
  } placed_pixel_t;

  typedef struct packed {
    logic [mrp_pkg::PIX_W-1:0]  pixel;
    logic                       typed;
    logic [mrp_pkg::ADDR_W-1:0] addr;
    logic                       done;
  } directed_row_t;

  typedef struct packed {
    logic [mrp_pkg::SIZE_W-1:0] width;
    logic [mrp_pkg::SIZE_W-1:0] height;
    logic [mrp_pkg::SAMP_W-1:0] h_samp;
    logic [mrp_pkg::SAMP_W-1:0] v_samp;
    logic [15:0]                beats;
  } image_setting_t;

  // Reset geometry is 8x8 with one block per MCU, so every pixel lands at its own index.
  localparam directed_row_t DIRECTED [20] = '{
    '{24'h000000, 1'b1, 32'd0,  1'b0}, '{24'hFFFFFF, 1'b1, 32'd1,  1'b0},
    '{24'h000001, 1'b1, 32'd2,  1'b0}, '{24'h800000, 1'b1, 32'd3,  1'b0},
    '{24'h555555, 1'b1, 32'd4,  1'b0}, '{24'hAAAAAA, 1'b1, 32'd5,  1'b0},
    '{24'h0000FF, 1'b1, 32'd6,  1'b0}, '{24'h00FF00, 1'b1, 32'd7,  1'b0},
    '{24'hFF0000, 1'b1, 32'd8,  1'b0}, '{24'h7FFFFF, 1'b1, 32'd9,  1'b0},
    '{24'h123456, 1'b0, 32'd0,  1'b0}, '{24'hFEDCBA, 1'b0, 32'd0,  1'b0},
    '{24'h00000F, 1'b1, 32'd12, 1'b0}, '{24'hF0F0F0, 1'b1, 32'd13, 1'b0},
    '{24'h0F0F0F, 1'b1, 32'd14, 1'b0}, '{24'h3C3C3C, 1'b1, 32'd15, 1'b0},
    '{24'hC3C3C3, 1'b1, 32'd16, 1'b0}, '{24'h999999, 1'b0, 32'd0,  1'b0},
    '{24'h666666, 1'b1, 32'd18, 1'b0}, '{24'h010203, 1'b1, 32'd19, 1'b0}
  };

  // Counters are never cleared between settings, so each change lands mid-image.
  localparam image_setting_t SETTINGS_LIST [8] = '{
    '{16'd8,     16'd8,     3'd1, 3'd1, 16'd60},
    '{16'd20,    16'd13,    3'd2, 3'd1, 16'd160},
    '{16'd0,     16'd0,     3'd0, 3'd0, 16'd120},
    '{16'd65535, 16'd65535, 3'd7, 3'd5, 16'd120},
    '{16'd1,     16'd1,     3'd4, 3'd4, 16'd100},
    '{16'd37,    16'd19,    3'd3, 3'd2, 16'd160},
    '{16'd5,     16'd65535, 3'd1, 3'd4, 16'd100},
    '{16'd65535, 16'd3,     3'd2, 3'd6, 16'd80}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_index_i;
  logic [15:0]         cfg_data_i;

  mrp_in_if  pix_in ();
  mrp_out_if pix_out ();

  mcu_to_raster_pixel_placer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_in_i    (pix_in),
    .pix_out_o   (pix_out)
  );

  // Shadow of the block's configuration and raster position.
  logic [mrp_pkg::SIZE_W-1:0] img_width;
  logic [mrp_pkg::SIZE_W-1:0] img_height;
  logic [mrp_pkg::SAMP_W-1:0] h_samp;
  logic [mrp_pkg::SAMP_W-1:0] v_samp;
  logic [4:0]                 col_in_mcu;
  logic [4:0]                 row_in_mcu;
  logic [15:0]                mcu_col;
  logic [15:0]                mcu_row;

  placed_pixel_t pending_pixels [$];
  int unsigned   err_count;
  int unsigned   cycle_count;
  int unsigned   beats_in;
  int unsigned   beats_out;
  int unsigned   images_done;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_pixels.size());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR: %s got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
    err_count++;
  endtask

  function automatic int unsigned clamp_sampling(input logic [mrp_pkg::SAMP_W-1:0] s);
    if (s == '0) return 1;
    if (s > mrp_pkg::SAMP_W'(mrp_pkg::MAX_SAMPLING)) return mrp_pkg::MAX_SAMPLING;
    return s;
  endfunction

  // Works out where one pixel lands, then steps the raster position.
  task automatic place_pixel(input logic [mrp_pkg::PIX_W-1:0] value, output bit kept,
                             output placed_pixel_t res);
    int unsigned     w;
    int unsigned     h;
    int unsigned     span_x;
    int unsigned     span_y;
    int unsigned     mcus_x;
    int unsigned     mcus_y;
    int unsigned     col;
    int unsigned     row;
    longint unsigned lin;
    w      = (img_width == '0) ? 1 : img_width;
    h      = (img_height == '0) ? 1 : img_height;
    span_x = clamp_sampling(h_samp) * 8;
    span_y = clamp_sampling(v_samp) * 8;
    mcus_x = (w + span_x - 1) / span_x;
    mcus_y = (h + span_y - 1) / span_y;
    col    = mcu_col * span_x + col_in_mcu;
    row    = mcu_row * span_y + row_in_mcu;
    kept   = col_in_mcu < span_x && row_in_mcu < span_y && mcu_col < mcus_x &&
             mcu_row < mcus_y && col < w && row < h;
    lin      = 64'(row) * 64'(w) + 64'(col);
    res.addr = lin[31:0];
    res.data = value;
    res.done = (col == w - 1) && (row == h - 1);

    col_in_mcu = col_in_mcu + 5'd1;
    if (col_in_mcu == '0 || col_in_mcu >= span_x) begin
      col_in_mcu = '0;
      row_in_mcu = row_in_mcu + 5'd1;
      if (row_in_mcu == '0 || row_in_mcu >= span_y) begin
        row_in_mcu = '0;
        mcu_col    = mcu_col + 16'd1;
        if (mcu_col == '0 || mcu_col >= mcus_x) begin
          mcu_col = '0;
          mcu_row = mcu_row + 16'd1;
          if (mcu_row >= mcus_y) mcu_row = '0;
        end
      end
    end
  endtask

  task automatic write_reg(input mrp_pkg::cfg_idx_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      mrp_pkg::CFG_IMAGE_WIDTH:  img_width  = value;
      mrp_pkg::CFG_IMAGE_HEIGHT: img_height = value;
      mrp_pkg::CFG_H_SAMPLING:   h_samp     = value[mrp_pkg::SAMP_W-1:0];
      mrp_pkg::CFG_V_SAMPLING:   v_samp     = value[mrp_pkg::SAMP_W-1:0];
      default: ;
    endcase
  endtask

  // Sampling writes carry random upper bits, which the block must ignore.
  task automatic apply_setting(input image_setting_t s);
    write_reg(mrp_pkg::CFG_IMAGE_WIDTH, s.width);
    write_reg(mrp_pkg::CFG_IMAGE_HEIGHT, s.height);
    write_reg(mrp_pkg::CFG_H_SAMPLING, {13'($urandom()), s.h_samp});
    write_reg(mrp_pkg::CFG_V_SAMPLING, {13'($urandom()), s.v_samp});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixel(input logic [mrp_pkg::PIX_W-1:0] value, input bit typed,
                            input placed_pixel_t typed_res);
    bit            kept;
    placed_pixel_t res;
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_in.valid       <= 1'b1;
    pix_in.pixel_value <= value;
    do @(posedge clk_i); while (!pix_in.ready);
    beats_in++;
    place_pixel(value, kept, res);
    if (kept) pending_pixels.push_back(typed ? typed_res : res);
  endtask

  // Drops valid and waits for every expected beat, then waits on so that any unexpected beat can show.
  task automatic drain();
    @(negedge clk_i);
    pix_in.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  always @(posedge clk_i) begin
    placed_pixel_t want;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      beats_out++;
      if (pix_out.image_done) images_done++;
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected beat, address", pix_out.pixel_address, '0);
      end else begin
        want = pending_pixels.pop_front();
        if (pix_out.pixel_address !== want.addr)
          report_mismatch("pixel_address", pix_out.pixel_address, want.addr);
        if (pix_out.pixel_data !== want.data)
          report_mismatch("pixel_data", 32'(pix_out.pixel_data), 32'(want.data));
        if (pix_out.image_done !== want.done)
          report_mismatch("image_done", 32'(pix_out.image_done), 32'(want.done));
      end
    end
  end

  initial begin
    placed_pixel_t  typed_res;
    image_setting_t s;
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = mrp_pkg::CFG_IMAGE_WIDTH;
    cfg_data_i         = '0;
    pix_in.valid       = 1'b0;
    pix_in.pixel_value = '0;
    pix_out.ready      = 1'b0;
    err_count          = 0;
    cycle_count        = 0;
    beats_in           = 0;
    beats_out          = 0;
    images_done        = 0;
    img_width          = 16'd8;
    img_height         = 16'd8;
    h_samp             = 3'd1;
    v_samp             = 3'd1;
    col_in_mcu         = '0;
    row_in_mcu         = '0;
    mcu_col            = '0;
    mcu_row            = '0;
    set_idling(0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 20; i++) begin
      typed_res.addr = DIRECTED[i].addr;
      typed_res.data = DIRECTED[i].pixel;
      typed_res.done = DIRECTED[i].done;
      send_pixel(DIRECTED[i].pixel, DIRECTED[i].typed, typed_res);
    end
    drain();

    // Fixed settings first, including the extremes, then a few small random images.
    for (int p = 0; p < 11; p++) begin
      if (p < 8) begin
        s = SETTINGS_LIST[p];
      end else begin
        s.width  = 16'($urandom_range(40));
        s.height = 16'($urandom_range(40));
        s.h_samp = 3'($urandom_range(7));
        s.v_samp = 3'($urandom_range(7));
        s.beats  = 16'd60;
      end
      set_idling(p % 4);
      apply_setting(s);
      for (int n = 0; n < s.beats; n++) send_pixel(24'($urandom()), 1'b0, typed_res);
      drain();
    end

    $display("Covered %0d input beats and %0d output beats over 12 image settings,",
             beats_in, beats_out);
    $display("with %0d last-pixel flags seen and %0d errors.", images_done, err_count);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== mcu_to_raster_pixel_placer.f =====
rtl/mrp_pkg.sv
rtl/mrp_in_if.sv
rtl/mrp_out_if.sv
rtl/mrp_pos.sv
rtl/mcu_to_raster_pixel_placer.sv
tb/tb_mcu_to_raster_pixel_placer.sv
